FILE: rtl/core/ppm_pkg.sv
// Shared types and constants for the PPM pulse-train decoder.
// No dependencies; imported by the top level, the front end and the back end.
package ppm_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int MAX_CHANNELS_DEF = 10;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Register reset values
    localparam logic [15:0] SYNC_GAP_RST = 16'd200;
    localparam logic [15:0] PEAK_LEN_RST = 16'd1024;

    // Queue depths between front, back and the result port
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic {
        REG_SYNC_GAP = 1'b0,
        REG_PEAK_LEN = 1'b1
    } reg_idx_t;

    // Result item kinds
    typedef enum logic {
        KIND_WIDTH     = 1'b0,
        KIND_FRAME_END = 1'b1
    } item_kind_t;

    typedef logic [4:0] held_t;
    typedef logic [3:0] chan_idx_t;

    // Frame-end request from front to back
    typedef struct packed {
        held_t       held;
        logic [31:0] count;
    } frame_cmd_t;

    // One result item
    typedef struct packed {
        item_kind_t  kind;
        chan_idx_t   idx;
        logic [31:0] value;
        logic        last;
    } out_item_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic      busy;
        chan_idx_t rd_idx;
    } back_stat_t;

endpackage

FILE: rtl/core/ppm_pulse_train_decoder.sv
// PPM pulse-train decoder, top level.
// Depends on ppm_pkg, ppm_fifo, ppm_front and ppm_back.
// Usage:
//   Samples enter through push/full/sample; one is taken at an edge where push
//   is high and full is low. Results leave as a queue: while empty is low the
//   oldest item sits on item_kind/channel_index/value/last and is taken by pop.
//   Registers (sync gap, peak block length) are written on cfg_valid/cfg_ready;
//   cfg_ready is always high.
// Flow:
//   A sample that causes no frame end has its magnitude registered, then the
//   slicer, edge timer and peak tracker update; full stays high meanwhile.
//   A frame end hands a request to the back end and intake holds full high
//   while it walks the width store, one width item per cycle while the result
//   queue has room, then the frame-end item.
//   A frame's first result reaches the result ports through the intake registers,
//   request queue, back-end state and result queue, given room in the latter.
// Reset: asynchronous, active low; clears counters, peaks and queues and loads
//   the register defaults. The width store is not cleared.
// Stalls: if pop stays low, the two-entry result queue fills and the back end
//   waits; intake stays blocked until the run is fully queued.
module ppm_pulse_train_decoder #(
    parameter int MAX_CHANNELS_HELD = ppm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS       = ppm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          empty,
    input  logic                          pop,
    output logic                          item_kind,
    output logic [3:0]                    channel_index,
    output logic [31:0]                   value,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data
);
    import ppm_pkg::*;

    frame_cmd_t cmd_in, cmd_out;
    logic       cmd_push, cmd_pop, cmd_empty, cmd_full;
    back_stat_t bk;
    logic [15:0] rd_width;
    out_item_t  item_in, item_out;
    logic       out_push, out_full;

    // Front end
    ppm_front #(
        .MAX_CHANNELS_HELD (MAX_CHANNELS_HELD),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_empty (cmd_empty),
        .bk        (bk),
        .rd_width  (rd_width)
    );

    // Frame request queue
    ppm_fifo #(
        .WIDTH ($bits(frame_cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Back end
    ppm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (item_in),
        .stat      (bk),
        .rd_width  (rd_width)
    );

    // Result queue
    ppm_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (item_in),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (item_out),
        .empty   (empty)
    );

    assign item_kind     = logic'(item_out.kind);
    assign channel_index = item_out.idx;
    assign value         = item_out.value;
    assign last          = item_out.last;

`ifndef SYNTHESIS
    // Request queue never overflows: intake blocks while a request is pending
    a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("top: frame request queue overflow");
`endif

endmodule

FILE: rtl/core/ppm_fifo.sv
// Small register-based FIFO, used for the frame request queue and result queue.
// Depends on nothing; width and depth are parameters.
module ppm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/ppm_front.sv
// Front end: sample intake, level slicing, peak tracking, edge timing and width store.
// Depends on ppm_pkg; issues frame-end requests to the back end through a queue.
module ppm_front #(
    parameter int MAX_CHANNELS_HELD = ppm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS       = ppm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data,
    // frame request queue
    output logic                          cmd_push,
    output ppm_pkg::frame_cmd_t           cmd,
    input  logic                          cmd_empty,
    // back-end status and width read port
    input  ppm_pkg::back_stat_t           bk,
    output logic [15:0]                   rd_width
);
    import ppm_pkg::*;

    localparam int    IDX_W    = (MAX_CHANNELS_HELD > 1) ? $clog2(MAX_CHANNELS_HELD) : 1;
    localparam held_t MAX_HELD = held_t'(MAX_CHANNELS_HELD);

    // Intake stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_mag_reg;
    logic [SAMPLE_BITS-1:0] mag_in;

    // Configuration
    logic [15:0] sync_gap_reg;
    logic [15:0] peak_len_reg;

    // Decoder state
    logic                   level_reg, level_next;
    logic [31:0]            cnt_reg, cnt_next;
    logic [31:0]            edge_reg, edge_next;
    held_t                  held_reg, held_next;
    logic [SAMPLE_BITS-1:0] thr_reg, thr_next;
    logic [SAMPLE_BITS-1:0] run_reg, run_next;
    logic [15:0]            bpos_reg, bpos_next;
    logic [15:0]            widths_reg [MAX_CHANNELS_HELD];

    // Working signals
    logic                   accept;
    logic [SAMPLE_BITS-1:0] run_upd;
    logic                   level;
    logic [31:0]            elapsed;
    logic                   rise;
    logic                   frame_end;
    logic                   store_width;
    logic [15:0]            blen;
    logic [15:0]            bp_inc;
    logic                   blk_end;

    // Intake blocked while a sample is in work or a frame run is pending
    assign full      = s1_valid_reg || !cmd_empty || bk.busy;
    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    // Magnitude; the most negative code maps onto itself as an unsigned value
    assign mag_in = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    // Level slicing and edge classification
    always_comb
    begin
        run_upd     = (s1_mag_reg > run_reg) ? s1_mag_reg : run_reg;
        level       = {s1_mag_reg, 1'b0} > {1'b0, thr_reg};
        elapsed     = cnt_reg - edge_reg;
        rise        = level && !level_reg;
        frame_end   = rise && (elapsed > {16'h0000, sync_gap_reg});
        store_width = rise && !frame_end && (held_reg < MAX_HELD);
        blen        = (peak_len_reg == 16'h0000) ? 16'h0001 : peak_len_reg;
        bp_inc      = bpos_reg + 16'h0001;
        blk_end     = (bp_inc >= blen) || (bp_inc == 16'h0000);
    end

    // Next state for one processed sample
    always_comb
    begin
        level_next = level_reg;
        cnt_next   = cnt_reg;
        edge_next  = edge_reg;
        held_next  = held_reg;
        thr_next   = thr_reg;
        run_next   = run_reg;
        bpos_next  = bpos_reg;
        if (s1_valid_reg)
        begin
            level_next = level;
            cnt_next   = cnt_reg + 32'd1;
            if (level != level_reg)
            begin
                edge_next = cnt_reg;
            end
            if (frame_end)
            begin
                held_next = '0;
            end
            else if (store_width)
            begin
                held_next = held_reg + 1'b1;
            end
            if (blk_end)
            begin
                thr_next  = run_upd;
                run_next  = '0;
                bpos_next = '0;
            end
            else
            begin
                run_next  = run_upd;
                bpos_next = bp_inc;
            end
        end
    end

    // Frame-end request
    assign cmd_push  = s1_valid_reg && frame_end;
    assign cmd.held  = held_reg;
    assign cmd.count = cnt_reg;

    // Width read for the back end
    assign rd_width = widths_reg[bk.rd_idx[IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sync_gap_reg <= SYNC_GAP_RST;
            peak_len_reg <= PEAK_LEN_RST;
            level_reg    <= 1'b0;
            cnt_reg      <= '0;
            edge_reg     <= '0;
            held_reg     <= '0;
            thr_reg      <= '0;
            run_reg      <= '0;
            bpos_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            level_reg    <= level_next;
            cnt_reg      <= cnt_next;
            edge_reg     <= edge_next;
            held_reg     <= held_next;
            thr_reg      <= thr_next;
            run_reg      <= run_next;
            bpos_reg     <= bpos_next;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_SYNC_GAP: sync_gap_reg <= cfg_data;
                    REG_PEAK_LEN: peak_len_reg <= cfg_data;
                    default:      sync_gap_reg <= sync_gap_reg;
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg <= mag_in;
        end
        if (s1_valid_reg && store_width)
        begin
            widths_reg[held_reg[IDX_W-1:0]] <= elapsed[15:0];
        end
    end

`ifndef SYNTHESIS
    // One sample in work at a time
    a_single_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> !s1_valid_reg)
        else $error("front: second sample entered while one was in work");

    // Width store never overfills
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= MAX_HELD)
        else $error("front: held channel count beyond store size");

    // A frame request only issues when the back end has nothing pending
    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd_empty && !bk.busy))
        else $error("front: frame request while back end still busy");
`endif

endmodule

FILE: rtl/core/ppm_back.sv
// Back end: expands a frame-end request into width items and a closing frame-end item.
// Depends on ppm_pkg; reads the width store held in the front end.
module ppm_back (
    input  logic                clk,
    input  logic                rst_n,
    // frame request queue
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  ppm_pkg::frame_cmd_t cmd,
    // result queue
    input  logic                out_full,
    output logic                out_push,
    output ppm_pkg::out_item_t  out_item,
    // status and width read
    output ppm_pkg::back_stat_t stat,
    input  logic [15:0]         rd_width
);
    import ppm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EMIT = 3'b010,
        ST_END  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    chan_idx_t   idx_reg, idx_next;
    held_t       held_reg, held_next;
    logic [31:0] count_reg, count_next;

    // Run sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        count_next     = count_reg;
        cmd_pop        = 1'b0;
        out_push       = 1'b0;
        out_item.kind  = KIND_WIDTH;
        out_item.idx   = idx_reg;
        out_item.value = {16'h0000, rd_width};
        out_item.last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    held_next  = cmd.held;
                    count_next = cmd.count;
                    idx_next   = '0;
                    state_next = (cmd.held != '0) ? ST_EMIT : ST_END;
                end
            end
            ST_EMIT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if ({1'b0, idx_reg} == held_reg - 1'b1)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_END:
            begin
                out_item.kind  = KIND_FRAME_END;
                out_item.idx   = '0;
                out_item.value = count_reg;
                out_item.last  = 1'b1;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.busy   = (state_reg != ST_IDLE);
    assign stat.rd_idx = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

`ifndef SYNTHESIS
    // Results are only written into a queue with room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("back: result written into full queue");

    // Width index stays inside the held run
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ({1'b0, idx_reg} < held_reg))
        else $error("back: width index past held count");

    // Taking a request always starts a run
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != ST_IDLE))
        else $error("back: request taken without starting a run");
`endif

endmodule
